>>> src/fcd_pkg.sv
// Shared types and constants for the force contact detector.
package fcd_pkg;

    // Field and register widths
    localparam int FORCE_W  = 24;
    localparam int CORR_W   = FORCE_W + 1;
    localparam int THRESH_W = 23;
    localparam int LIMIT_W  = 16;
    localparam int CFG_W    = 23;
    localparam int CFG_IDX_W = 1;
    localparam int DIR_W    = 2;

    // Register reset values
    localparam logic [THRESH_W-1:0] THRESH_RESET = 23'd51200;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd9;

    // Extra run length needed for backward contact
    localparam logic [LIMIT_W:0] BACKWARD_EXTRA = 17'd5;
    localparam logic [LIMIT_W-1:0] RUN_MAX = 16'hFFFF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 1'd1;

    // Item actions
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_RECAL  = 1'b1;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_NONE     = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_APPLY,
        ST_DIV,
        ST_DONE
    } fcd_state_t;

endpackage

>>> src/fcd_if.sv
// Valid/ready channel interfaces for sample input and contact result.
interface fcd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  action;
    logic signed [fcd_pkg::FORCE_W-1:0]    force_z;

    modport source (output valid, output action, output force_z, input ready);
    modport sink   (input valid, input action, input force_z, output ready);
endinterface

interface fcd_out_if;
    logic                              valid;
    logic                              ready;
    logic                              contact;
    logic [fcd_pkg::DIR_W-1:0]         direction;

    modport source (output valid, output contact, output direction, input ready);
    modport sink   (input valid, input contact, input direction, output ready);
endinterface

>>> src/force_contact_detector.sv
// Force contact detector top level: window, offset, debounce and sequencer.
//
// A force sample goes from acceptance to a result in the output register through
// EVAL, which reads the oldest window entry and forms the offset-corrected value,
// APPLY, which tests the threshold and updates the run counter, window and sum,
// and DONE, which loads the result once the output register is free or being read.
// A recalibrate item runs the bit-serial divider for the window mean, one quotient bit
// per cycle over the sum width (24 + clog2(WINDOW_DEPTH+1) bits, 29 at the default
// depth), then loads the result in DONE; on an empty window it goes straight to DONE.
// The block takes one item at a time; a new item is accepted while a finished
// result still waits in the output register. The window memory needs no
// clearing after reset.
module force_contact_detector #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [fcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fcd_pkg::CFG_W-1:0]       cfg_data,
    fcd_in_if.sink                          sample_ch,
    fcd_out_if.source                       result_ch
);

    localparam int FW     = fcd_pkg::FORCE_W;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W  = FW + FILL_W;

    fcd_pkg::fcd_state_t state_reg, state_next;

    // Configuration
    logic [fcd_pkg::THRESH_W-1:0] thresh_reg;
    logic [fcd_pkg::LIMIT_W-1:0]  limit_reg;

    // Detector state
    logic signed [SUM_W-1:0]      sum_reg, sum_next;
    logic [FILL_W-1:0]            fill_reg, fill_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic signed [FW-1:0]         offset_reg;
    logic [fcd_pkg::LIMIT_W-1:0]  run_reg, run_next;
    logic                         contact_reg, contact_next;
    logic [fcd_pkg::DIR_W-1:0]    dir_reg, dir_next;

    // Working registers
    logic signed [FW-1:0]             sample_reg;
    logic signed [FW-1:0]             old_reg;
    logic signed [fcd_pkg::CORR_W-1:0] corr_reg;
    logic                             neg_reg;

    // Window memory
    logic signed [FW-1:0] window_mem [WINDOW_DEPTH];

    // Output register
    logic                         out_valid_reg;
    logic                         out_contact_reg;
    logic [fcd_pkg::DIR_W-1:0]    out_dir_reg;

    // Sequencer outputs
    logic in_fire;
    logic div_start;
    logic do_eval;
    logic do_apply;
    logic load_out;

    // Divider
    logic                     div_done;
    logic [SUM_W-1:0]         div_quo;
    logic [SUM_W-1:0]         sum_mag;
    logic [FW-1:0]            mean_mag;

    // Datapath helpers
    logic                              win_full;
    logic signed [fcd_pkg::CORR_W-1:0] thr_ext;
    logic                              over;
    logic [fcd_pkg::LIMIT_W-1:0]       run_inc;
    logic [fcd_pkg::LIMIT_W:0]         limit_eff;

    assign in_fire  = sample_ch.valid && sample_ch.ready;
    assign win_full = fill_reg == FILL_W'(WINDOW_DEPTH);
    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mean_mag = div_quo[FW-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (sample_ch.action == fcd_pkg::ACT_SAMPLE)
                        state_next = fcd_pkg::ST_EVAL;
                    else if (fill_reg == '0)
                        state_next = fcd_pkg::ST_DONE;
                    else
                        state_next = fcd_pkg::ST_DIV;
                end
            end
            fcd_pkg::ST_EVAL:  state_next = fcd_pkg::ST_APPLY;
            fcd_pkg::ST_APPLY: state_next = fcd_pkg::ST_DONE;
            fcd_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = fcd_pkg::ST_DONE;
            end
            fcd_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result_ch.ready)
                    state_next = fcd_pkg::ST_IDLE;
            end
            default: state_next = fcd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        sample_ch.ready = state_reg == fcd_pkg::ST_IDLE;
        do_eval         = state_reg == fcd_pkg::ST_EVAL;
        do_apply        = state_reg == fcd_pkg::ST_APPLY;
        div_start       = (state_reg == fcd_pkg::ST_IDLE) && in_fire
                          && (sample_ch.action == fcd_pkg::ACT_RECAL) && (fill_reg != '0);
        load_out        = (state_reg == fcd_pkg::ST_DONE)
                          && (!out_valid_reg || result_ch.ready);
    end

    // Threshold test, run counter and window bookkeeping
    always_comb
    begin
        thr_ext   = {2'b00, thresh_reg};
        over      = (corr_reg > thr_ext) || (corr_reg < -thr_ext);
        run_inc   = (run_reg == fcd_pkg::RUN_MAX) ? run_reg
                                                  : run_reg + fcd_pkg::LIMIT_W'(1);
        limit_eff = corr_reg[fcd_pkg::CORR_W-1] ? ({1'b0, limit_reg} + fcd_pkg::BACKWARD_EXTRA)
                                                : {1'b0, limit_reg};
        run_next     = run_reg;
        contact_next = contact_reg;
        dir_next     = dir_reg;
        sum_next     = sum_reg;
        fill_next    = fill_reg;
        slot_next    = slot_reg;
        if (do_apply)
        begin
            if (over)
            begin
                run_next = run_inc;
                dir_next = corr_reg[fcd_pkg::CORR_W-1] ? fcd_pkg::DIR_BACKWARD
                                                       : fcd_pkg::DIR_FORWARD;
                if ({1'b0, run_inc} > limit_eff)
                    contact_next = 1'b1;
            end
            else
            begin
                run_next     = '0;
                contact_next = 1'b0;
            end
            sum_next = sum_reg + SUM_W'(sample_reg)
                       - (win_full ? SUM_W'(old_reg) : SUM_W'(0));
            if (!win_full)
                fill_next = fill_reg + FILL_W'(1);
            slot_next = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                : slot_reg + SLOT_W'(1);
        end
    end

    // Control and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcd_pkg::ST_IDLE;
            thresh_reg    <= fcd_pkg::THRESH_RESET;
            limit_reg     <= fcd_pkg::LIMIT_RESET;
            sum_reg       <= '0;
            fill_reg      <= '0;
            slot_reg      <= '0;
            offset_reg    <= '0;
            run_reg       <= '0;
            contact_reg   <= 1'b0;
            dir_reg       <= fcd_pkg::DIR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            fill_reg    <= fill_next;
            slot_reg    <= slot_next;
            run_reg     <= run_next;
            contact_reg <= contact_next;
            dir_reg     <= dir_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    fcd_pkg::REG_THRESHOLD: thresh_reg <= cfg_data[fcd_pkg::THRESH_W-1:0];
                    fcd_pkg::REG_LIMIT:     limit_reg  <= cfg_data[fcd_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // Offset: zero on an empty window, else the signed mean
            if (div_done)
                offset_reg <= neg_reg ? FW'(-mean_mag) : FW'(mean_mag);
            else if (in_fire && (sample_ch.action == fcd_pkg::ACT_RECAL) && (fill_reg == '0))
                offset_reg <= '0;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
            sample_reg <= sample_ch.force_z;
        if (div_start)
            neg_reg <= sum_reg[SUM_W-1];
        if (do_eval)
            corr_reg <= {sample_reg[FW-1], sample_reg} - {offset_reg[FW-1], offset_reg};
        if (load_out)
        begin
            out_contact_reg <= contact_reg;
            out_dir_reg     <= dir_reg;
        end
    end

    // Window memory: oldest entry read in EVAL, new sample written in APPLY
    always_ff @(posedge clk)
    begin
        if (do_eval)
            old_reg <= window_mem[slot_reg];
        if (do_apply)
            window_mem[slot_reg] <= sample_reg;
    end

    fcd_divider #(
        .DVD_W (SUM_W),
        .DVS_W (FILL_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign result_ch.valid     = out_valid_reg;
    assign result_ch.contact   = out_contact_reg;
    assign result_ch.direction = out_dir_reg;

endmodule

>>> src/fcd_divider.sv
// Bit-serial restoring divider: unsigned dividend by unsigned divisor.
module fcd_divider #(
    parameter int DVD_W = 29,
    parameter int DVS_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    // One quotient bit per cycle, dividend shifted out MSB first
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> src/fcd_checker.sv
// Port-level checks for the force contact detector, bound to the top level.
module fcd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          out_contact,
    input logic [fcd_pkg::DIR_W-1:0]     out_direction
);

    // A pending result stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transaction completed");

    // Direction code never takes the unused value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_direction == fcd_pkg::DIR_NONE
                       || out_direction == fcd_pkg::DIR_FORWARD
                       || out_direction == fcd_pkg::DIR_BACKWARD))
        else $error("invalid direction code");

    // Contact always comes with a known direction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_contact |-> out_direction != fcd_pkg::DIR_NONE)
        else $error("contact without direction");

    // One item in flight: ready drops after an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");

endmodule

bind force_contact_detector fcd_checker u_fcd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample_ch.valid),
    .in_ready      (sample_ch.ready),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .out_contact   (result_ch.contact),
    .out_direction (result_ch.direction)
);
